FILE: rtl/lft_pkg.sv
// Shared types and constants for the line field tokenizer.
package lft_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned LimitW = 16;
  localparam int unsigned ApbAw  = 3;
  localparam int unsigned ApbDw  = 32;

  // Register indexes on the configuration port (address bit 2)
  localparam logic RegLineFormat = 1'b0;
  localparam logic RegCharLimit  = 1'b1;

  localparam logic [LimitW-1:0] CharLimitRst = 16'd255;

  typedef struct packed {
    logic              line_format;
    logic [LimitW-1:0] field_char_limit;
  } lft_cfg_t;

  typedef struct packed {
    logic [CharW-1:0] char_out;
    logic             has_char;
    logic             field_last;
    logic             line_done;
    logic             truncated;
  } lft_result_t;

endpackage

FILE: rtl/lft_regs.sv
// Configuration registers behind the APB-style port.
module lft_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [lft_pkg::ApbAw-1:0] paddr,
  input  logic [lft_pkg::ApbDw-1:0] pwdata,
  output logic [lft_pkg::ApbDw-1:0] prdata,
  output logic                     pready,
  output lft_pkg::lft_cfg_t        cfg_o
);
  import lft_pkg::*;

  logic              fmt_q;
  logic [LimitW-1:0] limit_q;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= 1'b0;
      limit_q <= CharLimitRst;
    end else if (wr_en) begin
      case (paddr[2])
        RegLineFormat: fmt_q   <= pwdata[0];
        RegCharLimit:  limit_q <= pwdata[LimitW-1:0];
        default:       fmt_q   <= fmt_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegLineFormat: prdata = {{(ApbDw-1){1'b0}}, fmt_q};
      RegCharLimit:  prdata = {{(ApbDw-LimitW){1'b0}}, limit_q};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.line_format      = fmt_q;
  assign cfg_o.field_char_limit = limit_q;

endmodule

FILE: rtl/lft_core.sv
// Tokenizer state and the per-byte classification that updates it.
module lft_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [lft_pkg::CharW-1:0] text_byte_i,
  input  lft_pkg::lft_cfg_t        cfg_i,
  output logic                     res_valid_o,
  output lft_pkg::lft_result_t     res_o
);
  import lft_pkg::*;

  typedef enum logic [1:0] {
    PH_START   = 2'd0,
    PH_FIELD   = 2'd1,
    PH_COMMENT = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    CK_BARE   = 2'd0,
    CK_DQUOTE = 2'd1,
    CK_SQUOTE = 2'd2,
    CK_PAREN  = 2'd3
  } closer_e;

  localparam logic [CharW-1:0] ChNul    = 8'h00;
  localparam logic [CharW-1:0] ChTab    = 8'h09;
  localparam logic [CharW-1:0] ChLf     = 8'h0A;
  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChDquote = 8'h22;
  localparam logic [CharW-1:0] ChHash   = 8'h23;
  localparam logic [CharW-1:0] ChSquote = 8'h27;
  localparam logic [CharW-1:0] ChOpen   = 8'h28;
  localparam logic [CharW-1:0] ChClose  = 8'h29;

  phase_e            phase_q, phase_d;
  closer_e           closer_q, closer_d;
  logic [LimitW-1:0] count_q, count_d;
  logic              ovf_q, ovf_d;

  logic              do_take, do_end, end_done, end_trunc;
  logic [LimitW-1:0] count_base;
  logic              is_blank;
  logic [CharW-1:0]  c;

  assign c        = text_byte_i;
  assign is_blank = (c == ChSpace) || (c == ChTab);

  always_comb begin
    phase_d     = phase_q;
    closer_d    = closer_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    do_take     = 1'b0;
    do_end      = 1'b0;
    end_done    = 1'b0;
    end_trunc   = ovf_q;
    count_base  = count_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    case (phase_q)
      PH_COMMENT: begin
        if (c == ChLf || c == ChNul) phase_d = PH_START;
      end
      PH_FIELD: begin
        if (c == ChNul) begin
          do_end   = 1'b1;
          end_done = 1'b1;
        end else begin
          case (closer_q)
            CK_DQUOTE: if (c == ChDquote) do_end = 1'b1; else do_take = 1'b1;
            CK_SQUOTE: if (c == ChSquote) do_end = 1'b1; else do_take = 1'b1;
            CK_PAREN:  if (c == ChClose)  do_end = 1'b1; else do_take = 1'b1;
            default: begin
              if (c == ChLf) begin
                do_end   = 1'b1;
                end_done = 1'b1;
              end else if (!cfg_i.line_format && is_blank) begin
                do_end = 1'b1;
              end else begin
                do_take = 1'b1;
              end
            end
          endcase
        end
      end
      default: begin
        // Awaiting a field start; the unused phase code lands here too
        phase_d = PH_START;
        if (!is_blank) begin
          closer_d   = CK_BARE;
          count_d    = '0;
          ovf_d      = 1'b0;
          count_base = '0;
          if (c == ChHash || c == ChLf || c == ChNul) begin
            do_end    = 1'b1;
            end_done  = 1'b1;
            end_trunc = 1'b0;
            if (c == ChHash) phase_d = PH_COMMENT;
          end else begin
            phase_d = PH_FIELD;
            if (c == ChDquote) closer_d = CK_DQUOTE;
            else if (c == ChSquote) closer_d = CK_SQUOTE;
            else if (c == ChOpen && !cfg_i.line_format) closer_d = CK_PAREN;
            else do_take = 1'b1;
          end
        end
      end
    endcase

    if (do_take) begin
      if (count_base < cfg_i.field_char_limit) begin
        count_d        = count_base + LimitW'(1);
        res_valid_o    = 1'b1;
        res_o.char_out = c;
        res_o.has_char = 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end

    if (do_end) begin
      res_valid_o      = 1'b1;
      res_o.field_last = 1'b1;
      res_o.line_done  = end_done;
      res_o.truncated  = end_trunc;
      if (phase_d != PH_COMMENT) phase_d = PH_START;
      closer_d = CK_BARE;
      count_d  = '0;
      ovf_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      closer_q <= CK_BARE;
      count_q  <= '0;
      ovf_q    <= 1'b0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      closer_q <= closer_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
    end
  end

endmodule

FILE: rtl/lft_outbuf.sv
// Result register with a skid entry so input keeps flowing under output stalls.
module lft_outbuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lft_pkg::lft_result_t push_data_i,
  output logic                 can_push_o,
  output logic                 out_valid_o,
  output lft_pkg::lft_result_t out_data_o,
  input  logic                 out_ready_i
);
  import lft_pkg::*;

  logic        main_vld_q, skid_vld_q;
  lft_result_t main_q, skid_q;
  logic        pop;

  assign pop         = main_vld_q && out_ready_i;
  assign can_push_o  = !skid_vld_q;
  assign out_valid_o = main_vld_q;
  assign out_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!main_vld_q || pop) begin
      // Refill the result register from the skid entry first
      if (skid_vld_q) begin
        main_vld_q <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        main_vld_q <= push_i;
      end
    end else if (push_i) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_vld_q || pop) begin
      if (skid_vld_q) main_q <= skid_q;
      else if (push_i) main_q <= push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

endmodule

FILE: rtl/line_field_tokenizer.sv
// Top level of the line field tokenizer: stream ports, register port, assertions.
//
// Splits a byte stream of text lines into fields. Each accepted byte on the
// slave stream yields zero or one result on the master stream: a kept field
// character (tuser bit 0 set) or a field end (tlast set, tuser bit 1 when the
// line is finished, tuser bit 2 when characters beyond field_char_limit were
// dropped). Blanks before a field, bytes after '#' up to the line end, opening
// quotes and (in configuration lines) parentheses, and dropped characters give
// no result. The block takes one byte per clock cycle while s_axis_tready is
// high. The rate is set by the single state update per byte and by the two-entry
// registered result buffer (result register plus skid entry), which holds one
// more result while the output stalls; s_axis_tready drops only while both
// entries are held. Registers (APB, byte address 4*index): 0 line_format (0
// configuration lines, 1 playlist lines), 1 field_char_limit (reset 255). Write
// registers only while idle.
module line_field_tokenizer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // slave stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,  // [7:0] text_byte
  // master stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,  // [7:0] char_out
  output logic                      m_axis_tlast,  // field_last
  output logic [2:0]                m_axis_tuser,  // [0] has_char [1] line_done [2] truncated
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lft_pkg::ApbAw-1:0] paddr,
  input  logic [lft_pkg::ApbDw-1:0] pwdata,
  output logic [lft_pkg::ApbDw-1:0] prdata,
  output logic                      pready
);
  import lft_pkg::*;

  lft_cfg_t    cfg;
  lft_result_t res, out_res;
  logic        res_valid, accept, can_push;

  assign s_axis_tready = can_push;
  assign accept        = s_axis_tvalid && can_push;

  lft_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Classify the byte and advance field state on each transaction
  lft_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .text_byte_i (s_axis_tdata),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Hold results until the master side takes them
  lft_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && res_valid),
    .push_data_i (res),
    .can_push_o  (can_push),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_res),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = out_res.char_out;
  assign m_axis_tlast = out_res.field_last;
  assign m_axis_tuser = {out_res.truncated, out_res.line_done, out_res.has_char};

`ifndef NO_ASSERTIONS
  // Backpressure on the input only when the result register is occupied
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  // A character result never carries field end flags
  a_char_no_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (!m_axis_tlast && m_axis_tuser[2:1] == 2'b00))
    else $error("character result with end flags");

  // A field end carries no character
  a_end_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (!m_axis_tuser[0] && m_axis_tdata == 8'h00))
    else $error("field end with character data");

  // A stall leaves the pending result in place
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("pending result changed under stall");
`endif

endmodule
